[src/gbfr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbfr_pkg
// Shared types and constants for the binary frame receiver: parser phases,
// event codes, sync and acknowledge constants, and the bundles passed
// between the configuration, step and top-level modules.
// ----------------------------------------------------------------------------
package gbfr_pkg;

  localparam logic [7:0] SYNC_ONE   = 8'hB5;
  localparam logic [7:0] SYNC_TWO   = 8'h62;
  localparam logic [7:0] ACK_CLASS  = 8'h05;
  localparam logic [7:0] ACK_ID     = 8'h01;
  localparam logic [7:0] NMEA_START = 8'h24;
  localparam logic [16:0] PROBE_MAX_LEN = 17'd256;

  // Configuration register indexes.
  localparam logic [1:0] REG_MATCH_MODE   = 2'd0;
  localparam logic [1:0] REG_EXPECT_CLASS = 2'd1;
  localparam logic [1:0] REG_EXPECT_ID    = 2'd2;
  localparam logic [1:0] REG_MAX_PAYLOAD  = 2'd3;

  // Match modes. The spare encoding is handled like probe.
  localparam logic [1:0] MODE_ACK   = 2'd0;
  localparam logic [1:0] MODE_RESP  = 2'd1;
  localparam logic [1:0] MODE_PROBE = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_ACCEPT  = 3'd1,
    EV_CKSUM   = 3'd2,
    EV_TOOLONG = 3'd3,
    EV_NOMATCH = 3'd4,
    EV_NMEA    = 3'd5
  } event_t;

  typedef enum logic [8:0] {
    PH_HUNT   = 9'b000000001,
    PH_SYNC2  = 9'b000000010,
    PH_CLASS  = 9'b000000100,
    PH_ID     = 9'b000001000,
    PH_LEN_LO = 9'b000010000,
    PH_LEN_HI = 9'b000100000,
    PH_PAYLD  = 9'b001000000,
    PH_CK_A   = 9'b010000000,
    PH_CK_B   = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [1:0]  match_mode;
    logic [7:0]  expect_class;
    logic [7:0]  expect_id;
    logic [15:0] max_payload;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  frame_class;
    logic [7:0]  frame_ident;
    logic [15:0] frame_len;
    logic [15:0] byte_count;
    logic [7:0]  sum_a;
    logic [7:0]  sum_b;
    logic [7:0]  echo_class;
    logic [7:0]  echo_ident;
  } frame_state_t;

  typedef struct packed {
    event_t      event_res;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [15:0] frame_length;
  } result_t;

endpackage

[src/gbfr_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbfr_cfg_regs
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
module gbfr_cfg_regs import gbfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.match_mode   <= MODE_ACK;
      cfg.expect_class <= 8'd6;
      cfg.expect_id    <= 8'd0;
      cfg.max_payload  <= 16'd40;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MATCH_MODE:   cfg.match_mode   <= cfg_data[1:0];
        REG_EXPECT_CLASS: cfg.expect_class <= cfg_data[7:0];
        REG_EXPECT_ID:    cfg.expect_id    <= cfg_data[7:0];
        REG_MAX_PAYLOAD:  cfg.max_payload  <= cfg_data;
        default:          cfg.max_payload  <= cfg.max_payload;
      endcase
    end
  end

endmodule

[src/gbfr_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbfr_step
// Combinational parser step: from the current frame state, the configuration
// and one received byte, forms the next frame state and the result.
// ----------------------------------------------------------------------------
module gbfr_step import gbfr_pkg::*; (
  input  frame_state_t st,
  input  cfg_t         cfg,
  input  logic         func,
  input  logic [7:0]   rx_byte,
  output frame_state_t st_next,
  output result_t      res
);

  logic [1:0]  mode;
  logic [7:0]  sum_a_add;
  logic [7:0]  sum_b_add;
  logic [15:0] len_full;
  logic [15:0] count_inc;
  logic        too_long;
  logic        frame_ok;

  always_comb begin
    // The unused mode code behaves as probe.
    mode      = (cfg.match_mode == MODE_SPARE) ? MODE_PROBE : cfg.match_mode;
    sum_a_add = st.sum_a + rx_byte;
    sum_b_add = st.sum_b + sum_a_add;
    len_full  = {rx_byte, st.frame_len[7:0]};
    count_inc = st.byte_count + 16'd1;

    if (mode == MODE_RESP) begin
      too_long = len_full > cfg.max_payload;
    end else if (mode == MODE_PROBE) begin
      too_long = {1'b0, len_full} > PROBE_MAX_LEN;
    end else begin
      too_long = 1'b0;
    end

    if (mode == MODE_ACK) begin
      frame_ok = (st.frame_class == ACK_CLASS) && (st.frame_ident == ACK_ID) &&
                 (st.echo_class == cfg.expect_class) && (st.echo_ident == cfg.expect_id);
    end else if (mode == MODE_RESP) begin
      frame_ok = (st.frame_class == cfg.expect_class) && (st.frame_ident == cfg.expect_id);
    end else begin
      frame_ok = 1'b1;
    end
  end

  always_comb begin
    st_next = st;
    res     = '{event_res: EV_NONE, payload_valid: 1'b0, payload_byte: 8'd0,
                payload_index: 16'd0, frame_length: 16'd0};

    priority if (func) begin
      st_next.phase = PH_HUNT;
    end else if (mode == MODE_PROBE && rx_byte == NMEA_START) begin
      res.event_res = EV_NMEA;
      st_next.phase = PH_HUNT;
    end else begin
      unique case (st.phase)
        PH_SYNC2: begin
          if (rx_byte == SYNC_TWO) begin
            st_next.sum_a      = 8'd0;
            st_next.sum_b      = 8'd0;
            st_next.echo_class = 8'd0;
            st_next.echo_ident = 8'd0;
            st_next.byte_count = 16'd0;
            st_next.phase      = PH_CLASS;
          end else begin
            st_next.phase = PH_HUNT;
          end
        end
        PH_CLASS: begin
          st_next.frame_class = rx_byte;
          st_next.sum_a       = sum_a_add;
          st_next.sum_b       = sum_b_add;
          st_next.phase       = PH_ID;
        end
        PH_ID: begin
          st_next.frame_ident = rx_byte;
          st_next.sum_a       = sum_a_add;
          st_next.sum_b       = sum_b_add;
          st_next.phase       = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          st_next.frame_len = {8'd0, rx_byte};
          st_next.sum_a     = sum_a_add;
          st_next.sum_b     = sum_b_add;
          st_next.phase     = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          st_next.frame_len  = len_full;
          st_next.sum_a      = sum_a_add;
          st_next.sum_b      = sum_b_add;
          st_next.byte_count = 16'd0;
          if (too_long) begin
            res.event_res = EV_TOOLONG;
            st_next.phase = PH_HUNT;
          end else if (len_full == 16'd0) begin
            st_next.phase = PH_CK_A;
          end else begin
            st_next.phase = PH_PAYLD;
          end
        end
        PH_PAYLD: begin
          if (st.byte_count == 16'd0) st_next.echo_class = rx_byte;
          if (st.byte_count == 16'd1) st_next.echo_ident = rx_byte;
          if (mode == MODE_RESP) begin
            res.payload_valid = 1'b1;
            res.payload_byte  = rx_byte;
            res.payload_index = st.byte_count;
          end
          st_next.sum_a      = sum_a_add;
          st_next.sum_b      = sum_b_add;
          st_next.byte_count = count_inc;
          if (count_inc >= st.frame_len) st_next.phase = PH_CK_A;
        end
        PH_CK_A: begin
          if (rx_byte != st.sum_a) begin
            res.event_res = EV_CKSUM;
            st_next.phase = PH_HUNT;
          end else begin
            st_next.phase = PH_CK_B;
          end
        end
        PH_CK_B: begin
          if (rx_byte != st.sum_b) begin
            res.event_res = EV_CKSUM;
          end else if (frame_ok) begin
            res.event_res    = EV_ACCEPT;
            res.frame_length = st.frame_len;
          end else begin
            res.event_res = EV_NOMATCH;
          end
          st_next.phase = PH_HUNT;
        end
        default: begin
          st_next.phase = (rx_byte == SYNC_ONE) ? PH_SYNC2 : PH_HUNT;
        end
      endcase
    end
  end

endmodule

[src/gnss_binary_frame_receiver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnss_binary_frame_receiver
// Parses framed binary messages (sync pair, class, ID, length, payload,
// Fletcher checksum) from a received byte stream, one byte per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, func, rx_byte): each transaction is one
//   received byte, or a restart request when func is 1.
//   Output channel (out_valid/out_ready, event_res, payload_*, frame_length):
//   every input transaction produces exactly one output transaction carrying
//   the event code and, in response mode, the streamed payload byte.
//   Configuration port (cfg_we, cfg_index, cfg_data): single-cycle writes to
//   match_mode, expect_class, expect_id and max_payload; write only while idle.
// Result timing and rate:
//   A byte accepted at one edge has its result registered at that edge, so the
//   result is visible from the cycle after. The parser step is a single pass of
//   adds and compares, so one byte is accepted every cycle unless the output stalls.
// Stalls:
//   The result register is the only buffer. in_ready is high when it is empty
//   or being drained in the same cycle, so a stalled receiver holds back the
//   input after one pending result.
// Reset:
//   rst clears the parser to hunting for sync, clears all frame state and the
//   output register, and loads the configuration defaults.
// ----------------------------------------------------------------------------
module gnss_binary_frame_receiver import gbfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  event_res,
  output logic        payload_valid,
  output logic [7:0]  payload_byte,
  output logic [15:0] payload_index,
  output logic [15:0] frame_length,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t         cfg;
  frame_state_t st;
  frame_state_t st_next;
  result_t      res_next;
  result_t      res;
  logic         in_fire;

  gbfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  gbfr_step u_step (
    .st      (st),
    .cfg     (cfg),
    .func    (func),
    .rx_byte (rx_byte),
    .st_next (st_next),
    .res     (res_next)
  );

  // A new byte may enter whenever the result register is free or draining.
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Parser state advances only on an accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{phase: PH_HUNT, default: '0};
    end else if (in_fire) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res <= '{event_res: EV_NONE, default: '0};
    end else if (in_fire) begin
      res <= res_next;
    end
  end

  assign event_res     = res.event_res;
  assign payload_valid = res.payload_valid;
  assign payload_byte  = res.payload_byte;
  assign payload_index = res.payload_index;
  assign frame_length  = res.frame_length;

endmodule
